// File: rtl/core/aos_pkg.sv
// Shared types and constants for the analog output scaler.
`default_nettype none

package aos_pkg;

    localparam int DEF_VALUE_WIDTH = 48;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int RAW_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [RAW_WIDTH-1:0] RAW_MAX = 32'h7fff_ffff;
    localparam logic [RAW_WIDTH-1:0] RAW_MIN = 32'h8000_0000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_DRIVE_HIGH = 3'd0,
        REG_DRIVE_LOW  = 3'd1,
        REG_RATE_LIMIT = 3'd2,
        REG_ENG_SLOPE  = 3'd3,
        REG_ENG_OFFSET = 3'd4,
        REG_ADJ_SLOPE  = 3'd5,
        REG_ADJ_OFFSET = 3'd6,
        REG_RAW_OFFSET = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLAMP,
        OP_RATE_DIFF,
        OP_RATE_PICK,
        OP_ENG_OFFSET,
        OP_ENG_DIV,
        OP_TAKE_QUOT,
        OP_ADJ_OFFSET,
        OP_ADJ_DIV,
        OP_RAW_OFFSET,
        OP_MAGNITUDE,
        OP_ROUND
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   publish;
    } aos_cmd_t;

    typedef struct packed {
        logic eng_slope_zero;
        logic adj_slope_zero;
        logic div_done;
    } aos_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/aos_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module aos_div
    import aos_pkg::*;
#(
    parameter int NUM_WIDTH = 83,
    parameter int DEN_WIDTH = DEF_VALUE_WIDTH
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [NUM_WIDTH-1:0] dividend,
    input  wire logic signed [DEN_WIDTH-1:0] divisor,
    output logic                             done,
    output logic signed [NUM_WIDTH-1:0]      quotient
);

    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 neg_reg;
    logic [NUM_WIDTH-1:0] num_reg;
    logic [DEN_WIDTH-1:0] den_reg;
    logic [DEN_WIDTH-1:0] rem_reg;

    logic [DEN_WIDTH:0]   part;
    logic [DEN_WIDTH+1:0] trial;
    logic                 fits;
    logic [DEN_WIDTH-1:0] rem_next;
    logic [NUM_WIDTH-1:0] num_next;

    always_comb
    begin
        part     = {rem_reg, num_reg[NUM_WIDTH-1]};
        trial    = {1'b0, part} - {2'b00, den_reg};
        fits     = ~trial[DEN_WIDTH+1];
        rem_next = fits ? trial[DEN_WIDTH-1:0] : part[DEN_WIDTH-1:0];
        num_next = {num_reg[NUM_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[NUM_WIDTH-1] ^ divisor[DEN_WIDTH-1];
            num_reg <= dividend[NUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;
            den_reg <= divisor[DEN_WIDTH-1] ? (~divisor + 1'b1) : divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~num_reg + 1'b1) : num_reg;

endmodule

`default_nettype wire

// File: rtl/core/aos_dp.sv
// Datapath: configuration registers, clamp, slew limit, scaling and rounding.
`default_nettype none

module aos_dp
    import aos_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int IN_WIDTH    = ((DEF_VALUE_WIDTH + 7) / 8) * 8,
    parameter int OUT_WIDTH   = ((2 * DEF_VALUE_WIDTH + RAW_WIDTH + 1 + 7) / 8) * 8
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [VALUE_WIDTH-1:0]     cfg_data,
    input  wire logic [IN_WIDTH-1:0]        in_data,
    input  wire aos_cmd_t                   cmd,
    output aos_stat_t                       stat,
    output logic [OUT_WIDTH-1:0]            out_data
);

    localparam int W  = VALUE_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int IW = VALUE_WIDTH + 2 * FRAC_BITS + 3;
    localparam int RW = RAW_WIDTH;

    logic signed [W-1:0] drive_high_reg;
    logic signed [W-1:0] drive_low_reg;
    logic        [W-2:0] rate_limit_reg;
    logic signed [W-1:0] eng_slope_reg;
    logic signed [W-1:0] eng_offset_reg;
    logic signed [W-1:0] adj_slope_reg;
    logic signed [W-1:0] adj_offset_reg;
    logic       [RW-1:0] raw_offset_reg;
    logic signed [W-1:0] last_reg;

    logic signed [W-1:0]  v_reg;
    logic signed [W-1:0]  clamped_reg;
    logic signed [W-1:0]  outv_reg;
    logic                 changed_reg;
    logic signed [W:0]    diff_reg;
    logic signed [W:0]    step_reg;
    logic signed [IW-1:0] x_reg;
    logic                 sign_reg;
    logic [RW-1:0]        raw_reg;
    logic [OUT_WIDTH-1:0] out_data_reg;

    logic signed [W-1:0]  clamp_next;
    logic [W:0]           mag;
    logic                 limit_hit;
    logic signed [W-1:0]  outv_next;
    logic signed [IW-1:0] eng_next;
    logic signed [IW-1:0] adj_next;
    logic signed [IW-1:0] raw_next;
    logic [IW-1:0]        rounded;
    logic                 big;
    logic [RW-1:0]        raw_mag;
    logic [RW-1:0]        round_next;

    logic                 div_start;
    logic signed [IW-1:0] div_num;
    logic signed [W-1:0]  div_den;
    logic signed [IW-1:0] quot;
    logic                 div_done;

    always_comb
    begin
        clamp_next = v_reg;
        if (drive_high_reg > drive_low_reg)
        begin
            if (v_reg > drive_high_reg)
                clamp_next = drive_high_reg;
            else if (v_reg < drive_low_reg)
                clamp_next = drive_low_reg;
        end

        mag       = diff_reg[W] ? (~diff_reg + 1'b1) : diff_reg;
        limit_hit = (rate_limit_reg != '0) && ({2'b00, rate_limit_reg} < mag);
        outv_next = limit_hit ? step_reg[W-1:0] : v_reg;

        eng_next = eng_slope_reg == '0 ? '0 :
                   {{(IW-W){outv_reg[W-1]}}, outv_reg}
                   - {{(IW-W){eng_offset_reg[W-1]}}, eng_offset_reg};
        adj_next = x_reg - {{(IW-W){adj_offset_reg[W-1]}}, adj_offset_reg};
        raw_next = x_reg - {{(IW-RW-F){1'b0}}, raw_offset_reg, {F{1'b0}}};

        rounded    = x_reg + {{(IW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
        big        = |rounded[IW-1:F+RW-1];
        raw_mag    = {1'b0, rounded[F+RW-2:F]};
        if (sign_reg)
            round_next = big ? RAW_MIN : (~raw_mag + 1'b1);
        else
            round_next = big ? RAW_MAX : raw_mag;
    end

    assign div_start = (cmd.op == OP_ENG_DIV) || (cmd.op == OP_ADJ_DIV);
    assign div_num   = {x_reg[IW-1-F:0], {F{1'b0}}};
    assign div_den   = (cmd.op == OP_ADJ_DIV) ? adj_slope_reg : eng_slope_reg;

    aos_div #(
        .NUM_WIDTH (IW),
        .DEN_WIDTH (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (quot)
    );

    assign stat = '{
        eng_slope_zero: (eng_slope_reg == '0),
        adj_slope_zero: (adj_slope_reg == '0),
        div_done:       div_done
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_high_reg <= '0;
            drive_low_reg  <= '0;
            rate_limit_reg <= '0;
            eng_slope_reg  <= W'(1) << F;
            eng_offset_reg <= '0;
            adj_slope_reg  <= '0;
            adj_offset_reg <= '0;
            raw_offset_reg <= '0;
            last_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_DRIVE_HIGH: drive_high_reg <= cfg_data;
                    REG_DRIVE_LOW:  drive_low_reg  <= cfg_data;
                    REG_RATE_LIMIT: rate_limit_reg <= cfg_data[W-2:0];
                    REG_ENG_SLOPE:  eng_slope_reg  <= cfg_data;
                    REG_ENG_OFFSET: eng_offset_reg <= cfg_data;
                    REG_ADJ_SLOPE:  adj_slope_reg  <= cfg_data;
                    REG_ADJ_OFFSET: adj_offset_reg <= cfg_data;
                    REG_RAW_OFFSET: raw_offset_reg <= cfg_data[RW-1:0];
                endcase
            end
            if (cmd.op == OP_RATE_PICK)
                last_reg <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                v_reg <= in_data[W-1:0];
            end
            OP_CLAMP:
            begin
                v_reg       <= clamp_next;
                clamped_reg <= clamp_next;
            end
            OP_RATE_DIFF:
            begin
                diff_reg <= {v_reg[W-1], v_reg} - {last_reg[W-1], last_reg};
                if (v_reg < last_reg)
                    step_reg <= {last_reg[W-1], last_reg} - {2'b00, rate_limit_reg};
                else
                    step_reg <= {last_reg[W-1], last_reg} + {2'b00, rate_limit_reg};
            end
            OP_RATE_PICK:
            begin
                outv_reg    <= outv_next;
                changed_reg <= (outv_next != last_reg);
            end
            OP_ENG_OFFSET: x_reg <= eng_next;
            OP_TAKE_QUOT:  x_reg <= quot;
            OP_ADJ_OFFSET: x_reg <= adj_next;
            OP_RAW_OFFSET: x_reg <= raw_next;
            OP_MAGNITUDE:
            begin
                sign_reg <= x_reg[IW-1];
                x_reg    <= x_reg[IW-1] ? (~x_reg + 1'b1) : x_reg;
            end
            OP_ROUND:      raw_reg <= round_next;
            OP_NONE, OP_ENG_DIV, OP_ADJ_DIV:
            begin
            end
            default:
            begin
            end
        endcase

        if (cmd.publish)
            out_data_reg <= OUT_WIDTH'({raw_reg, changed_reg, outv_reg, clamped_reg});
    end

    assign out_data = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/aos_ctrl.sv
// Controller: sequences the datapath steps and runs both stream handshakes.
`default_nettype none

module aos_ctrl
    import aos_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire aos_stat_t stat,
    output aos_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_RATE_DIFF,
        ST_RATE_PICK,
        ST_ENG_OFFSET,
        ST_ENG_DIV,
        ST_ENG_WAIT,
        ST_ADJ_OFFSET,
        ST_ADJ_DIV,
        ST_ADJ_WAIT,
        ST_RAW_OFFSET,
        ST_MAGNITUDE,
        ST_ROUND,
        ST_PUBLISH
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;

    always_comb
    begin
        cmd.publish = (state_reg == ST_PUBLISH) && (!m_tvalid_reg || m_tready);
        unique case (state_reg)
            ST_IDLE:       cmd.op = (s_tvalid && s_tready_reg) ? OP_LOAD : OP_NONE;
            ST_CLAMP:      cmd.op = OP_CLAMP;
            ST_RATE_DIFF:  cmd.op = OP_RATE_DIFF;
            ST_RATE_PICK:  cmd.op = OP_RATE_PICK;
            ST_ENG_OFFSET: cmd.op = OP_ENG_OFFSET;
            ST_ENG_DIV:    cmd.op = OP_ENG_DIV;
            ST_ENG_WAIT:   cmd.op = stat.div_done ? OP_TAKE_QUOT : OP_NONE;
            ST_ADJ_OFFSET: cmd.op = OP_ADJ_OFFSET;
            ST_ADJ_DIV:    cmd.op = OP_ADJ_DIV;
            ST_ADJ_WAIT:   cmd.op = stat.div_done ? OP_TAKE_QUOT : OP_NONE;
            ST_RAW_OFFSET: cmd.op = OP_RAW_OFFSET;
            ST_MAGNITUDE:  cmd.op = OP_MAGNITUDE;
            ST_ROUND:      cmd.op = OP_ROUND;
            ST_PUBLISH:    cmd.op = OP_NONE;
            default:       cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.publish)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready_reg)
                    begin
                        s_tready_reg <= 1'b0;
                        state_reg    <= ST_CLAMP;
                    end
                end
                ST_CLAMP:      state_reg <= ST_RATE_DIFF;
                ST_RATE_DIFF:  state_reg <= ST_RATE_PICK;
                ST_RATE_PICK:  state_reg <= ST_ENG_OFFSET;
                ST_ENG_OFFSET: state_reg <= stat.eng_slope_zero ? ST_ADJ_OFFSET : ST_ENG_DIV;
                ST_ENG_DIV:    state_reg <= ST_ENG_WAIT;
                ST_ENG_WAIT:
                begin
                    if (stat.div_done)
                        state_reg <= ST_ADJ_OFFSET;
                end
                ST_ADJ_OFFSET: state_reg <= stat.adj_slope_zero ? ST_RAW_OFFSET : ST_ADJ_DIV;
                ST_ADJ_DIV:    state_reg <= ST_ADJ_WAIT;
                ST_ADJ_WAIT:
                begin
                    if (stat.div_done)
                        state_reg <= ST_RAW_OFFSET;
                end
                ST_RAW_OFFSET: state_reg <= ST_MAGNITUDE;
                ST_MAGNITUDE:  state_reg <= ST_ROUND;
                ST_ROUND:      state_reg <= ST_PUBLISH;
                ST_PUBLISH:
                begin
                    if (cmd.publish)
                    begin
                        s_tready_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:       state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// File: rtl/core/analog_output_scaler.sv
// Top level of the analog output scaler: controller, datapath and stream ports.
`default_nettype none

// Each item is one engineering setpoint (signed fixed point, FRAC_BITS fraction bits).
// The block clamps it to the drive limits (when the high limit exceeds the low),
// limits its change from the previous output, scales it to a raw device value and
// rounds that half away from zero with 32-bit saturation. One item is in work at a
// time; its run time is set by the shared divider, which retires one quotient bit
// per cycle and runs twice per item; a zero slope skips its division. A finished
// result waits in the output register while the next item is taken. Write the
// configuration only while idle.
module analog_output_scaler
    import aos_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0]           cfg_index,
    input  wire logic [VALUE_WIDTH-1:0]               cfg_data,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // setpoint
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // clamped_value, output_value, output_changed, raw_value
    output logic [((2*VALUE_WIDTH+RAW_WIDTH+1+7)/8)*8-1:0] m_tdata
);

    localparam int IN_WIDTH  = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_WIDTH = ((2 * VALUE_WIDTH + RAW_WIDTH + 1 + 7) / 8) * 8;

    aos_cmd_t  cmd;
    aos_stat_t stat;

    aos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    aos_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .IN_WIDTH    (IN_WIDTH),
        .OUT_WIDTH   (OUT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire
